### rtl/assert_macros.svh
// Assertion helpers for the RTL, included by the core module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cst_pkg.sv
package cst_pkg;

  // Capacity of the list and the widths that follow from it.
  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Operation codes.
  localparam logic [3:0] OP_START    = 4'd0;
  localparam logic [3:0] OP_END      = 4'd1;
  localparam logic [3:0] OP_PARK     = 4'd2;
  localparam logic [3:0] OP_ADVANCE  = 4'd3;
  localparam logic [3:0] OP_RETREAT  = 4'd4;
  localparam logic [3:0] OP_INSERT   = 4'd5;
  localparam logic [3:0] OP_ATTACH   = 4'd6;
  localparam logic [3:0] OP_REMOVE   = 4'd7;
  localparam logic [3:0] OP_INSFRONT = 4'd8;
  localparam logic [3:0] OP_APPEND   = 4'd9;
  localparam logic [3:0] OP_REMFRONT = 4'd10;
  localparam logic [3:0] OP_READCUR  = 4'd11;
  localparam logic [3:0] OP_READIDX  = 4'd12;

  // Status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_NOCUR  = 2'd2;
  localparam logic [1:0] STAT_BADIDX = 2'd3;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] value;
    logic [5:0]         index;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [6:0]         item_count;
    logic [6:0]         cursor_pos;
    logic               has_current;
    logic [1:0]         status;
  } out_t;

  // Broadcast to every cell of the row in the cycle of a transfer.
  typedef struct packed {
    logic               shift_up;
    logic               shift_dn;
    logic [IDX_W-1:0]   pos;
    logic signed [31:0] value;
  } cell_ctrl_t;

endpackage

### rtl/cst_cell.sv
module cst_cell (
  input  logic                      clk,
  input  cst_pkg::cell_ctrl_t       ctrl,
  input  logic [cst_pkg::IDX_W-1:0] cell_idx,
  input  logic signed [31:0]        from_left,
  input  logic signed [31:0]        from_right,
  output logic signed [31:0]        data
);
  import cst_pkg::*;

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  // Take the new value at the gap, the left neighbour above it when opening
  // a gap, or the right neighbour from the gap upwards when closing one.
  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift_up) begin
      if (cell_idx == ctrl.pos) begin
        data_nxt = ctrl.value;
      end else if (cell_idx > ctrl.pos) begin
        data_nxt = from_left;
      end
    end else if (ctrl.shift_dn) begin
      if (cell_idx >= ctrl.pos) begin
        data_nxt = from_right;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

### rtl/cst_row.sv
module cst_row (
  input  logic                      clk,
  input  cst_pkg::cell_ctrl_t       ctrl,
  input  logic [cst_pkg::IDX_W-1:0] rd_addr,
  output logic signed [31:0]        rd_data
);
  import cst_pkg::*;

  logic signed [31:0] cell_q [DEPTH];

  // Chain of cells, each wired to its two neighbours.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_in;
    logic signed [31:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = ctrl.value;
    end else begin : g_inner_l
      assign left_in = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_inner_r
      assign right_in = cell_q[i+1];
    end

    cst_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_idx   (IDX_W'(i)),
      .from_left  (left_in),
      .from_right (right_in),
      .data       (cell_q[i])
    );
  end

  // Read port onto the row; the caller registers the result.
  assign rd_data = cell_q[rd_addr];

endmodule

### rtl/cursor_sequence_table_core.sv
// Sequencing: a transfer at start moves the core into ST_READ; out_valid and the
// result are both registered at the end of that state, so out_valid strobes after it.
// busy is high in the cycle after a transfer, while the row's read selection is
// registered into the result, so a new item is not taken until that is done.
// Reset (rst_n low, synchronous) empties the list and parks the cursor at once;
// entry contents are not cleared. Results cannot be held off by the receiver.
`include "assert_macros.svh"

module cursor_sequence_table_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  cst_pkg::in_t  in_item,
  output logic          out_valid,
  output cst_pkg::out_t out_item
);
  import cst_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cursor_r, cursor_nxt;
  logic             parked_r, parked_nxt;
  logic             out_valid_r;
  out_t             out_r;

  // Per-item results held for the read cycle.
  logic             idx_mode_r;
  logic             idx_ok_r;
  logic [5:0]       index_r;
  logic [1:0]       status_r;

  logic             accept;
  logic             cur;
  logic             full;
  logic             idx_ok;
  logic [1:0]       status_nxt;
  cell_ctrl_t       ctrl;
  logic [IDX_W-1:0] rd_addr;
  logic signed [31:0] rd_data;
  logic             cur_after;

  assign busy   = (state_r == ST_READ);
  assign accept = start && !busy;
  assign cur    = !parked_r && (cursor_r < count_r);
  assign full   = (count_r >= CNT_W'(DEPTH));
  assign idx_ok = (in_item.index < count_r);

  // Decode of one operation against the list's control state.
  always_comb begin
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    parked_nxt    = parked_r;
    status_nxt    = STAT_OK;
    ctrl.shift_up = 1'b0;
    ctrl.shift_dn = 1'b0;
    ctrl.pos      = '0;
    ctrl.value    = in_item.value;
    case (in_item.op)
      OP_START, OP_END: begin
        if (count_r == '0) begin
          parked_nxt = 1'b1;
        end else begin
          cursor_nxt = (in_item.op == OP_START) ? '0 : count_r - 1'b1;
          parked_nxt = 1'b0;
        end
      end
      OP_PARK: begin
        parked_nxt = 1'b1;
      end
      OP_ADVANCE: begin
        if (!cur) begin
          status_nxt = STAT_NOCUR;
        end else begin
          cursor_nxt = cursor_r + 1'b1;
          if (cursor_r + 1'b1 >= count_r) parked_nxt = 1'b1;
        end
      end
      OP_RETREAT: begin
        if (!cur) begin
          status_nxt = STAT_NOCUR;
        end else if (cursor_r == '0) begin
          parked_nxt = 1'b1;
        end else begin
          cursor_nxt = cursor_r - 1'b1;
        end
      end
      OP_INSERT, OP_ATTACH, OP_INSFRONT: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          if (in_item.op == OP_INSERT) begin
            ctrl.pos = cur ? cursor_r[IDX_W-1:0] : '0;
          end else if (in_item.op == OP_ATTACH) begin
            ctrl.pos = cur ? cursor_r[IDX_W-1:0] + 1'b1 : count_r[IDX_W-1:0];
          end else begin
            ctrl.pos = '0;
          end
          ctrl.shift_up = 1'b1;
          count_nxt     = count_r + 1'b1;
          cursor_nxt    = CNT_W'(ctrl.pos);
          parked_nxt    = 1'b0;
        end
      end
      OP_REMOVE: begin
        if (!cur) begin
          status_nxt = STAT_NOCUR;
        end else begin
          ctrl.shift_dn = 1'b1;
          ctrl.pos      = cursor_r[IDX_W-1:0];
          count_nxt     = count_r - 1'b1;
          if (cursor_r >= count_r - 1'b1) parked_nxt = 1'b1;
        end
      end
      OP_APPEND: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          ctrl.shift_up = 1'b1;
          ctrl.pos      = count_r[IDX_W-1:0];
          count_nxt     = count_r + 1'b1;
        end
      end
      OP_REMFRONT: begin
        if (count_r == '0) begin
          status_nxt = STAT_NOCUR;
        end else begin
          ctrl.shift_dn = 1'b1;
          ctrl.pos      = '0;
          count_nxt     = count_r - 1'b1;
          cursor_nxt    = '0;
          parked_nxt    = (count_r == CNT_W'(1));
        end
      end
      OP_READCUR: begin
        if (!cur) status_nxt = STAT_NOCUR;
      end
      OP_READIDX: begin
        if (!idx_ok) status_nxt = STAT_BADIDX;
      end
      default: begin
      end
    endcase
    // Gate the broadcast so the row only moves on a transfer.
    if (!accept) begin
      ctrl.shift_up = 1'b0;
      ctrl.shift_dn = 1'b0;
    end
  end

  // Row of entry cells.
  cst_row u_row (
    .clk     (clk),
    .ctrl    (ctrl),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // In the read cycle the control registers already hold the post-op state.
  assign cur_after = cur;
  assign rd_addr   = idx_mode_r ? IDX_W'(index_r) : cursor_r[IDX_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state of the list and the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      parked_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_READ);
      if (accept) begin
        count_r  <= count_nxt;
        cursor_r <= cursor_nxt;
        parked_r <= parked_nxt;
      end
    end
  end

  // Item details carried to the read cycle, and the result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_mode_r <= (in_item.op == OP_READIDX);
      idx_ok_r   <= idx_ok;
      index_r    <= in_item.index;
      status_r   <= status_nxt;
    end
    if (state_r == ST_READ) begin
      if (idx_mode_r) begin
        out_r.read_value <= idx_ok_r ? rd_data : '0;
      end else begin
        out_r.read_value <= cur_after ? rd_data : '0;
      end
      out_r.item_count  <= 7'(count_r);
      out_r.cursor_pos  <= cur_after ? 7'(cursor_r) : 7'(count_r);
      out_r.has_current <= cur_after;
      out_r.status      <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `ASSERT_NEXT(a_read_strobes, state_r == ST_READ, out_valid_r, "read cycle gave no result")
  `ASSERT_SAME(a_cursor_in_range, !parked_r, cursor_r < count_r, "live cursor beyond list")
  `ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count above capacity")
  `ASSERT_SAME(a_no_accept_busy, state_r == ST_READ, !accept, "transfer taken while busy")
  `ASSERT_SAME(a_cur_pos, out_valid_r && out_r.has_current,
               out_r.cursor_pos < out_r.item_count, "current flag without entry")

endmodule
